// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the voice allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define PVA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define PVA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hdl/pva_pkg.sv =====
// Package for the polyphonic voice allocator: codes, constants and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int unsigned MAX_VOICES_DEF = 16;

  localparam logic [31:0] TAG_START   = 32'd23456;
  localparam logic [19:0] MUTE_RESET  = 20'd8820;

  // Input event kinds (s_axis_tuser).
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_OFF_NOTE = 2'd1;
  localparam logic [1:0] KIND_OFF_TAG  = 2'd2;
  localparam logic [1:0] KIND_TICK     = 2'd3;

  // Result commands (m_axis_tuser).
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // Configuration registers, at byte address 8 * index.
  localparam int unsigned ADDR_W = 5;
  localparam logic [1:0] REG_VOICE_COUNT = 2'd0;
  localparam logic [1:0] REG_CHANNEL_MAP = 2'd1;
  localparam logic [1:0] REG_MUTE_TICKS  = 2'd2;

  typedef struct packed {
    logic [4:0]  voice_count;
    logic [63:0] channel_map;
    logic [19:0] mute_ticks;
  } pva_cfg_t;

  typedef struct packed {
    logic        lt;
    logic        eq;
    logic [31:0] diff;
  } pva_alu_res_t;

endpackage

// ===== hdl/pva_alu.sv =====
// Shared 32-bit subtract unit of the voice allocator: a - b with borrow and zero flags.
// Serves tag ordering, tag match and countdown decrement; depends on pva_pkg.
`timescale 1ns / 1ps

module pva_alu (
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  output pva_pkg::pva_alu_res_t res_o
);

  logic [32:0] diff;

  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.lt   = diff[32];
  assign res_o.eq   = (diff[31:0] == 32'd0);
  assign res_o.diff = diff[31:0];

endmodule

// ===== hdl/pva_cfg_regs.sv =====
// APB register file of the voice allocator: voice count, channel map, release length.
// Depends on pva_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps

module pva_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pva_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  output pva_pkg::pva_cfg_t            cfg_o
);

  logic [1:0]        reg_idx;
  logic              wr_en;
  pva_pkg::pva_cfg_t cfg_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voice_count <= 5'd0;
      cfg_q.channel_map <= 64'd0;
      cfg_q.mute_ticks  <= pva_pkg::MUTE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        pva_pkg::REG_VOICE_COUNT: cfg_q.voice_count <= pwdata[4:0];
        pva_pkg::REG_CHANNEL_MAP: cfg_q.channel_map <= pwdata;
        pva_pkg::REG_MUTE_TICKS:  cfg_q.mute_ticks  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pva_pkg::REG_VOICE_COUNT: prdata = 64'(cfg_q.voice_count);
      pva_pkg::REG_CHANNEL_MAP: prdata = cfg_q.channel_map;
      pva_pkg::REG_MUTE_TICKS:  prdata = 64'(cfg_q.mute_ticks);
      default:                  prdata = 64'd0;
    endcase
  end

endmodule

// ===== hdl/polyphonic_voice_allocator.sv =====
// Channel  | Dir | Beat contents
// s_axis   | in  | tuser: kind; tdata: note, velocity, channel, target_tag
// m_axis   | out | tuser: command; tdata: voice .. sounding_mask; tlast: last result
// APB      | in  | voice_count @0x00, voice_channel_map @0x08, mute_ticks @0x10
// Each event scans the voices in use one per cycle through a single 32-bit subtract unit.
// Note-on and tick scan every voice in use; note-off by note scans them and then walks them
// again to emit one release per match; note-off by tag stops its scan at the first match.
// Results wait while m_axis stalls.
// s_axis_tready is high only between events. rst_ni clears all voices and resets the tag counter to TAG_START.
// Top level of the voice allocator; depends on pva_pkg, pva_alu, pva_cfg_regs, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module polyphonic_voice_allocator #(
  parameter int unsigned MAX_VOICES = pva_pkg::MAX_VOICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [6:0] note, [13:7] velocity, [17:14] channel, [49:18] target_tag, [55:50] zero
  input  logic [55:0]                s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [3:0] voice, [10:4] out_note, [17:11] out_velocity, [49:18] voice_tag,
  // [50] status, [66:51] sounding_mask, [71:67] zero
  output logic [71:0]                m_axis_tdata,
  // [1:0] command
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pva_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  localparam int unsigned VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VOICES + 1);
  localparam int unsigned MV = MAX_VOICES;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_TICK   = 3'd4;

  pva_pkg::pva_cfg_t     cfg;
  pva_pkg::pva_alu_res_t alu;
  logic [31:0]           alu_a, alu_b;

  logic [2:0]    state_q, state_d;
  logic [1:0]    kind_q, kind_d;
  logic [6:0]    note_q, note_d;
  logic [6:0]    vel_q, vel_d;
  logic [3:0]    chan_q, chan_d;
  logic [31:0]   ttag_q, ttag_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          free_found_q, free_found_d;
  logic [VW-1:0] free_idx_q, free_idx_d;
  logic          min_found_q, min_found_d;
  logic [VW-1:0] min_idx_q, min_idx_d;
  logic [31:0]   min_tag_q, min_tag_d;
  logic [MV-1:0] match_q, match_d;
  logic [MV-1:0] sound_q, sound_d;
  logic [31:0]   next_tag_q;

  // Voice state.
  logic [MV-1:0] busy_q;
  logic [MV-1:0] gate_q;
  logic [6:0]    note_mem [MV];
  logic [31:0]   tag_mem  [MV];
  logic [19:0]   left_mem [MV];

  // Result register.
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic          out_free;
  logic [1:0]    out_cmd_q, out_cmd_d;
  logic [3:0]    out_voice_q, out_voice_d;
  logic [6:0]    out_note_q, out_note_d;
  logic [6:0]    out_vel_q, out_vel_d;
  logic [31:0]   out_tag_q, out_tag_d;
  logic          out_status_q, out_status_d;
  logic [15:0]   out_mask_q, out_mask_d;
  logic          out_last_q, out_last_d;

  logic [CW-1:0] n_voices;
  logic [VW-1:0] vi;
  logic [VW-1:0] pick;
  logic          busy_rd, gate_rd, ch_hit;
  logic [6:0]    note_rd;
  logic [31:0]   tag_rd;
  logic [19:0]   left_rd;
  logic [MV-1:0] rest_mask;
  logic          start_en, rel_en, tick_en;

  pva_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pva_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  always_comb begin
    if (cfg.voice_count > 5'(MAX_VOICES)) begin
      n_voices = CW'(MAX_VOICES);
    end else begin
      n_voices = cfg.voice_count[CW-1:0];
    end
  end

  assign vi        = idx_q[VW-1:0];
  assign pick      = free_found_q ? free_idx_q : min_idx_q;
  assign busy_rd   = busy_q[vi];
  assign gate_rd   = gate_q[vi];
  assign note_rd   = note_mem[vi];
  assign tag_rd    = tag_mem[vi];
  assign left_rd   = left_mem[vi];
  assign ch_hit    = (cfg.channel_map[{vi, 2'b00} +: 4] == chan_q);
  assign rest_mask = match_q & ~(MV'(1) << vi);
  assign out_free  = !out_valid_q || m_axis_tready;

  // The shared unit orders tags on note-on, matches the tag on note-off by tag,
  // and decrements the countdown on tick.
  always_comb begin
    case (kind_q)
      pva_pkg::KIND_NOTE_ON: begin
        alu_a = tag_rd;
        alu_b = min_tag_q;
      end
      pva_pkg::KIND_OFF_TAG: begin
        alu_a = tag_rd;
        alu_b = ttag_q;
      end
      default: begin
        alu_a = 32'(left_rd);
        alu_b = 32'd1;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    note_d       = note_q;
    vel_d        = vel_q;
    chan_d       = chan_q;
    ttag_d       = ttag_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    min_found_d  = min_found_q;
    min_idx_d    = min_idx_q;
    min_tag_d    = min_tag_q;
    match_d      = match_q;
    sound_d      = sound_q;
    start_en     = 1'b0;
    rel_en       = 1'b0;
    tick_en      = 1'b0;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_cmd_d    = pva_pkg::CMD_NONE;
    out_voice_d  = 4'd0;
    out_note_d   = 7'd0;
    out_vel_d    = 7'd0;
    out_tag_d    = 32'd0;
    out_status_d = 1'b0;
    out_mask_d   = 16'd0;
    out_last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d       = s_axis_tuser;
          note_d       = s_axis_tdata[6:0];
          vel_d        = s_axis_tdata[13:7];
          chan_d       = s_axis_tdata[17:14];
          ttag_d       = s_axis_tdata[49:18];
          idx_d        = '0;
          free_found_d = 1'b0;
          min_found_d  = 1'b0;
          match_d      = '0;
          sound_d      = '0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (idx_q >= n_voices) begin
          case (kind_q)
            pva_pkg::KIND_NOTE_ON: state_d = ST_COMMIT;
            pva_pkg::KIND_TICK:    state_d = ST_TICK;
            default: begin
              idx_d   = '0;
              state_d = ST_EMIT;
            end
          endcase
        end else begin
          idx_d = idx_q + CW'(1);
          case (kind_q)
            pva_pkg::KIND_NOTE_ON: begin
              if (ch_hit && !busy_rd && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = vi;
              end
              // Strict compare keeps the lowest index among equal tags.
              if (ch_hit && (!min_found_q || alu.lt)) begin
                min_found_d = 1'b1;
                min_idx_d   = vi;
                min_tag_d   = tag_rd;
              end
            end
            pva_pkg::KIND_OFF_NOTE: begin
              if (busy_rd && (note_rd == note_q) && ch_hit) begin
                match_d[vi] = 1'b1;
              end
            end
            pva_pkg::KIND_OFF_TAG: begin
              if (busy_rd && alu.eq) begin
                match_d[vi] = 1'b1;
                idx_d       = '0;
                state_d     = ST_EMIT;
              end
            end
            default: begin
              if (gate_rd || (left_rd != 20'd0)) begin
                sound_d[vi] = 1'b1;
              end
              if (left_rd != 20'd0) begin
                tick_en = 1'b1;
              end
            end
          endcase
        end
      end

      ST_COMMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (free_found_q || min_found_q) begin
            start_en    = 1'b1;
            out_cmd_d   = pva_pkg::CMD_START;
            out_voice_d = 4'(pick);
            out_note_d  = note_q;
            out_vel_d   = vel_q;
            out_tag_d   = next_tag_q;
          end else begin
            out_status_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (match_q == '0) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (!match_q[vi]) begin
          idx_d = idx_q + CW'(1);
        end else if (out_free) begin
          rel_en      = 1'b1;
          out_load    = 1'b1;
          out_cmd_d   = pva_pkg::CMD_RELEASE;
          out_voice_d = 4'(vi);
          out_note_d  = note_rd;
          out_vel_d   = vel_q;
          out_tag_d   = tag_rd;
          out_last_d  = (rest_mask == '0);
          match_d[vi] = 1'b0;
          idx_d       = idx_q + CW'(1);
          if (rest_mask == '0) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_TICK: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_cmd_d  = pva_pkg::CMD_TICK;
          out_mask_d = 16'(sound_q);
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      min_found_q  <= 1'b0;
      match_q      <= '0;
      out_valid_q  <= 1'b0;
      next_tag_q   <= pva_pkg::TAG_START;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      min_found_q  <= min_found_d;
      match_q      <= match_d;
      out_valid_q  <= out_valid_d;
      if (start_en) begin
        next_tag_q <= next_tag_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    note_q     <= note_d;
    vel_q      <= vel_d;
    chan_q     <= chan_d;
    ttag_q     <= ttag_d;
    free_idx_q <= free_idx_d;
    min_idx_q  <= min_idx_d;
    min_tag_q  <= min_tag_d;
    sound_q    <= sound_d;
    if (out_load) begin
      out_cmd_q    <= out_cmd_d;
      out_voice_q  <= out_voice_d;
      out_note_q   <= out_note_d;
      out_vel_q    <= out_vel_d;
      out_tag_q    <= out_tag_d;
      out_status_q <= out_status_d;
      out_mask_q   <= out_mask_d;
      out_last_q   <= out_last_d;
    end
  end

  // Busy, gate and countdown come out of reset cleared; note and tag are only
  // read for busy voices, so they are written on note-on alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      gate_q <= '0;
      for (int i = 0; i < MV; i++) begin
        left_mem[i] <= 20'd0;
      end
    end else begin
      if (start_en) begin
        busy_q[pick]   <= 1'b1;
        gate_q[pick]   <= 1'b1;
        left_mem[pick] <= 20'd0;
      end
      if (rel_en) begin
        gate_q[vi]   <= 1'b0;
        left_mem[vi] <= cfg.mute_ticks;
        if (cfg.mute_ticks == 20'd0) begin
          busy_q[vi] <= 1'b0;
        end
      end
      if (tick_en) begin
        left_mem[vi] <= alu.diff[19:0];
        if (alu.diff[19:0] == 20'd0) begin
          busy_q[vi] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_en) begin
      note_mem[pick] <= note_q;
      tag_mem[pick]  <= next_tag_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_cmd_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_mask_q, out_status_q, out_tag_q, out_vel_q,
                          out_note_q, out_voice_q};

  `PVA_ASSERT(a_accept_starts_scan, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_SCAN), "accepted beat did not start a scan")
  `PVA_ASSERT(a_tag_advances, clk_i, rst_ni, start_en |=> (next_tag_q == ($past(next_tag_q) + 32'd1)), "tag counter did not advance on voice start")
  `PVA_ASSERT(a_idle_no_pending, clk_i, rst_ni, (state_q == ST_IDLE) |-> (match_q == '0), "release matches left over when idle")
  `PVA_ASSERT_NEVER(a_release_gate, clk_i, rst_ni, $past(rel_en) && gate_q[$past(vi)], "released voice still gated")

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the polyphonic voice allocator: a directed table, then random
// MIDI-style events under varying backpressure, checked against a voice bank model kept here.
// Depends on pva_pkg and the polyphonic_voice_allocator top level.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_VOICES = 16;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned PHASE_EVENTS = 67;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [3:0]  chan;
    logic [31:0] tag;
  } midi_event_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  voice;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] tag;
    logic        status;
    logic [15:0] mask;
    logic        last;
  } voice_cmd_t;

  typedef struct {
    bit          is_write;
    logic [1:0]  reg_idx;
    logic [63:0] wval;
    midi_event_t ev;
    bit          typed;
    voice_cmd_t  want;
  } step_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [55:0]                s_axis_tdata = '0;
  logic [1:0]                 s_axis_tuser = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [71:0]                m_axis_tdata;
  logic [1:0]                 m_axis_tuser;
  logic                       m_axis_tlast;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [pva_pkg::ADDR_W-1:0] paddr = '0;
  logic [63:0]                pwdata = '0;
  logic [63:0]                prdata;
  logic                       pready;

  // Voice bank as seen from outside, plus its configuration.
  logic [4:0]  cfg_count = 5'd0;
  logic [63:0] cfg_map = 64'd0;
  logic [19:0] cfg_mute = pva_pkg::MUTE_RESET;
  logic        v_busy [NUM_VOICES];
  logic [6:0]  v_note [NUM_VOICES];
  logic [31:0] v_tag [NUM_VOICES];
  logic        v_gate [NUM_VOICES];
  logic [19:0] v_left [NUM_VOICES];
  logic [31:0] next_tag = pva_pkg::TAG_START;

  voice_cmd_t  fresh_cmds[$];
  voice_cmd_t  pending_cmds[$];
  step_row_t   directed_rows[$];
  logic [6:0]  note_pool [4] = '{7'd60, 7'd62, 7'd64, 7'd67};

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold = 1'b0;
  bit          hold_start = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  voice_cmd_t  mon_got;
  voice_cmd_t  mon_want;

  polyphonic_voice_allocator uut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      v_busy[i] = 1'b0;
      v_note[i] = '0;
      v_tag[i] = '0;
      v_gate[i] = 1'b0;
      v_left[i] = '0;
    end
  end

  function automatic int unsigned active_voices();
    return (cfg_count > NUM_VOICES) ? NUM_VOICES : int'(cfg_count);
  endfunction

  function automatic logic [3:0] chan_of(int unsigned v);
    return cfg_map[4*v +: 4];
  endfunction

  function automatic voice_cmd_t cmd_of(logic [1:0] cmd, logic [3:0] voice, logic [6:0] note,
                                        logic [6:0] vel, logic [31:0] tag, logic status,
                                        logic [15:0] mask);
    voice_cmd_t c;
    c.cmd = cmd;
    c.voice = voice;
    c.note = note;
    c.vel = vel;
    c.tag = tag;
    c.status = status;
    c.mask = mask;
    c.last = 1'b0;
    return c;
  endfunction

  function automatic midi_event_t mk_ev(logic [1:0] kind, logic [6:0] note, logic [6:0] vel,
                                       logic [3:0] chan, logic [31:0] tag);
    midi_event_t ev;
    ev.kind = kind;
    ev.note = note;
    ev.vel = vel;
    ev.chan = chan;
    ev.tag = tag;
    return ev;
  endfunction

  function automatic void release_voice(int unsigned v);
    v_gate[v] = 1'b0;
    v_left[v] = cfg_mute;
    if (cfg_mute == 20'd0) v_busy[v] = 1'b0;
  endfunction

  // Applies one event to the voice bank and leaves the commands it causes in fresh_cmds.
  function automatic void allocate_voices(midi_event_t ev);
    int unsigned n;
    int pick;
    logic [15:0] mask;
    n = active_voices();
    pick = -1;
    mask = '0;
    fresh_cmds.delete();
    case (ev.kind)
      pva_pkg::KIND_NOTE_ON: begin
        for (int i = 0; i < n; i++)
          if (pick < 0 && !v_busy[i] && chan_of(i) == ev.chan) pick = i;
        // No free voice: steal the oldest one on the channel.
        if (pick < 0)
          for (int i = 0; i < n; i++)
            if (chan_of(i) == ev.chan && (pick < 0 || v_tag[i] < v_tag[pick])) pick = i;
        if (pick < 0) begin
          fresh_cmds.push_back(cmd_of(pva_pkg::CMD_NONE, '0, '0, '0, '0, 1'b1, '0));
        end else begin
          v_tag[pick] = next_tag;
          next_tag = next_tag + 32'd1;
          v_note[pick] = ev.note;
          v_busy[pick] = 1'b1;
          v_gate[pick] = 1'b1;
          v_left[pick] = '0;
          fresh_cmds.push_back(cmd_of(pva_pkg::CMD_START, 4'(pick), ev.note, ev.vel,
                                      v_tag[pick], 1'b0, '0));
        end
      end
      pva_pkg::KIND_OFF_NOTE: begin
        for (int i = 0; i < n; i++)
          if (v_busy[i] && v_note[i] == ev.note && chan_of(i) == ev.chan) begin
            release_voice(i);
            fresh_cmds.push_back(cmd_of(pva_pkg::CMD_RELEASE, 4'(i), v_note[i], ev.vel,
                                        v_tag[i], 1'b0, '0));
          end
        if (fresh_cmds.size() == 0)
          fresh_cmds.push_back(cmd_of(pva_pkg::CMD_NONE, '0, '0, '0, '0, 1'b1, '0));
      end
      pva_pkg::KIND_OFF_TAG: begin
        for (int i = 0; i < n; i++)
          if (pick < 0 && v_busy[i] && v_tag[i] == ev.tag) pick = i;
        if (pick < 0) begin
          fresh_cmds.push_back(cmd_of(pva_pkg::CMD_NONE, '0, '0, '0, '0, 1'b1, '0));
        end else begin
          release_voice(pick);
          fresh_cmds.push_back(cmd_of(pva_pkg::CMD_RELEASE, 4'(pick), v_note[pick], ev.vel,
                                      v_tag[pick], 1'b0, '0));
        end
      end
      default: begin
        // The mask is taken before the countdowns move.
        for (int i = 0; i < n; i++) begin
          if (v_gate[i] || v_left[i] != 0) mask[i] = 1'b1;
          if (v_left[i] != 0) begin
            v_left[i] = v_left[i] - 20'd1;
            if (v_left[i] == 0) v_busy[i] = 1'b0;
          end
        end
        fresh_cmds.push_back(cmd_of(pva_pkg::CMD_TICK, '0, '0, '0, '0, 1'b0, mask));
      end
    endcase
    fresh_cmds[fresh_cmds.size()-1].last = 1'b1;
  endfunction

  function automatic string fmt_cmd(voice_cmd_t c);
    return $sformatf("cmd=%0d voice=%0d note=%0d vel=%0d tag=%h status=%0d mask=%h last=%0d",
                     c.cmd, c.voice, c.note, c.vel, c.tag, c.status, c.mask, c.last);
  endfunction

  function automatic void report_mismatch(string what, string want, string got);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch, %s\n  expected %s\n  actual   %s",
                                   $time, what, want, got);
  endfunction

  function automatic midi_event_t random_event();
    midi_event_t ev;
    int unsigned n;
    int unsigned r;
    n = active_voices();
    ev.note = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : note_pool[$urandom_range(3)];
    ev.vel = 7'($urandom_range(127));
    ev.tag = $urandom();
    ev.chan = (n == 0 || $urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                 : chan_of($urandom_range(n - 1));
    r = $urandom_range(99);
    if (r < 35) ev.kind = pva_pkg::KIND_NOTE_ON;
    else if (r < 55) ev.kind = pva_pkg::KIND_OFF_NOTE;
    else if (r < 70) ev.kind = pva_pkg::KIND_OFF_TAG;
    else ev.kind = pva_pkg::KIND_TICK;
    if (n != 0 && ev.kind == pva_pkg::KIND_OFF_NOTE && $urandom_range(1) == 0)
      ev.note = v_note[$urandom_range(n - 1)];
    if (ev.kind == pva_pkg::KIND_OFF_TAG) begin
      r = $urandom_range(99);
      if (n != 0 && r < 75) ev.tag = v_tag[$urandom_range(n - 1)];
      else if (r < 85) ev.tag = next_tag - 32'd1;
    end
    return ev;
  endfunction

  task automatic send_event(midi_event_t ev, bit typed, voice_cmd_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= ev.kind;
    s_axis_tdata <= {6'b0, ev.tag, ev.chan, ev.vel, ev.note};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    allocate_voices(ev);
    events_sent++;
    if (typed) pending_cmds.push_back(want);
    else foreach (fresh_cmds[i]) pending_cmds.push_back(fresh_cmds[i]);
    // The block is busy scanning right after a beat, so dropping valid here never delays the next beat.
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block idle: every result back and the scan finished.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    logic [63:0] readback;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      pva_pkg::REG_VOICE_COUNT: cfg_count = val[4:0];
      pva_pkg::REG_CHANNEL_MAP: cfg_map = val;
      default: cfg_mute = val[19:0];
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      pva_pkg::REG_VOICE_COUNT: val = {59'b0, val[4:0]};
      pva_pkg::REG_MUTE_TICKS: val = {44'b0, val[19:0]};
      default: ;
    endcase
    if (readback !== val)
      report_mismatch($sformatf("register %0d read back", idx), $sformatf("%h", val),
                      $sformatf("%h", readback));
  endtask

  function automatic void add_wr(logic [1:0] idx, logic [63:0] val);
    step_row_t row;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.wval = val;
    row.ev = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_ev(midi_event_t ev, bit typed, voice_cmd_t want);
    step_row_t row;
    row.is_write = 1'b0;
    row.reg_idx = '0;
    row.wval = '0;
    row.ev = ev;
    row.typed = typed;
    row.want = want;
    row.want.last = 1'b1;
    directed_rows.push_back(row);
  endfunction

  // Long receiver stall, timed here so the sender keeps offering beats meanwhile.
  initial begin
    wait (hold_start);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(negedge clk_i) m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got.cmd = m_axis_tuser;
      mon_got.voice = m_axis_tdata[3:0];
      mon_got.note = m_axis_tdata[10:4];
      mon_got.vel = m_axis_tdata[17:11];
      mon_got.tag = m_axis_tdata[49:18];
      mon_got.status = m_axis_tdata[50];
      mon_got.mask = m_axis_tdata[66:51];
      mon_got.last = m_axis_tlast;
      cmd_seen[mon_got.cmd]++;
      if (m_axis_tdata[71:67] != 0)
        report_mismatch("nonzero pad bits", "00", $sformatf("%h", m_axis_tdata[71:67]));
      if (pending_cmds.size() == 0) begin
        report_mismatch("result beat with nothing pending", "none", fmt_cmd(mon_got));
      end else begin
        mon_want = pending_cmds.pop_front();
        if (mon_got !== mon_want) report_mismatch("result beat", fmt_cmd(mon_want),
                                                  fmt_cmd(mon_got));
      end
    end
  end

  initial begin
    logic [63:0] map;
    voice_cmd_t none_cmd;
    none_cmd = cmd_of(pva_pkg::CMD_NONE, '0, '0, '0, '0, 1'b1, '0);

    // Nothing is in use after reset, so every event finds no voice.
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd60, 7'd100, 4'd0, 32'd0), 1'b1, none_cmd);
    add_ev(mk_ev(pva_pkg::KIND_TICK, 7'd0, 7'd0, 4'd0, 32'd0), 1'b1,
           cmd_of(pva_pkg::CMD_TICK, '0, '0, '0, '0, 1'b0, '0));
    add_ev(mk_ev(pva_pkg::KIND_OFF_NOTE, 7'd60, 7'd5, 4'd0, 32'd0), 1'b1, none_cmd);
    add_ev(mk_ev(pva_pkg::KIND_OFF_TAG, 7'd0, 7'd0, 4'd0, pva_pkg::TAG_START), 1'b1, none_cmd);
    // Voices 0 and 1 on channel 0, voices 2 and 3 on channel 15.
    add_wr(pva_pkg::REG_VOICE_COUNT, 64'd4);
    add_wr(pva_pkg::REG_CHANNEL_MAP, 64'h5555_5555_5555_FF00);
    add_wr(pva_pkg::REG_MUTE_TICKS, 64'd2);
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd127, 7'd127, 4'd0, 32'd0), 1'b1,
           cmd_of(pva_pkg::CMD_START, 4'd0, 7'd127, 7'd127, pva_pkg::TAG_START, 1'b0, '0));
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd0, 7'd0, 4'd0, 32'd0), 1'b1,
           cmd_of(pva_pkg::CMD_START, 4'd1, 7'd0, 7'd0, pva_pkg::TAG_START + 32'd1, 1'b0,
                  '0));
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd64, 7'd1, 4'd0, 32'd0), 1'b0, '0);
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd127, 7'd2, 4'd15, 32'd0), 1'b0, '0);
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd127, 7'd3, 4'd15, 32'd0), 1'b0, '0);
    add_ev(mk_ev(pva_pkg::KIND_OFF_NOTE, 7'd127, 7'd9, 4'd15, 32'd0), 1'b0, '0);
    repeat (3) add_ev(mk_ev(pva_pkg::KIND_TICK, 7'd0, 7'd0, 4'd0, 32'd0), 1'b0, '0);
    add_ev(mk_ev(pva_pkg::KIND_OFF_TAG, 7'd0, 7'd11, 4'd0, pva_pkg::TAG_START + 32'd1), 1'b0,
           '0);
    add_ev(mk_ev(pva_pkg::KIND_OFF_TAG, 7'd0, 7'd11, 4'd0, 32'hFFFF_FFFF), 1'b1, none_cmd);
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd40, 7'd20, 4'd7, 32'd0), 1'b1, none_cmd);
    // A second note-off during release restarts the countdown.
    add_ev(mk_ev(pva_pkg::KIND_OFF_NOTE, 7'd64, 7'd30, 4'd0, 32'd0), 1'b0, '0);
    add_ev(mk_ev(pva_pkg::KIND_TICK, 7'd0, 7'd0, 4'd0, 32'd0), 1'b0, '0);
    add_ev(mk_ev(pva_pkg::KIND_OFF_NOTE, 7'd64, 7'd31, 4'd0, 32'd0), 1'b0, '0);
    repeat (2) add_ev(mk_ev(pva_pkg::KIND_TICK, 7'd0, 7'd0, 4'd0, 32'd0), 1'b0, '0);
    // With a zero release length the voice is free right away, so its tag no longer matches.
    add_wr(pva_pkg::REG_MUTE_TICKS, 64'd0);
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd50, 7'd60, 4'd15, 32'd0), 1'b0, '0);
    add_ev(mk_ev(pva_pkg::KIND_OFF_TAG, 7'd0, 7'd61, 4'd0, pva_pkg::TAG_START + 32'd5), 1'b0,
           '0);
    add_ev(mk_ev(pva_pkg::KIND_OFF_TAG, 7'd0, 7'd62, 4'd0, pva_pkg::TAG_START + 32'd5), 1'b1,
           none_cmd);
    // Voices 2 and 3 drop out of use, so channel 15 has no voice.
    add_wr(pva_pkg::REG_VOICE_COUNT, 64'd2);
    add_ev(mk_ev(pva_pkg::KIND_NOTE_ON, 7'd51, 7'd63, 4'd15, 32'd0), 1'b1, none_cmd);
    add_ev(mk_ev(pva_pkg::KIND_TICK, 7'd0, 7'd0, 4'd0, 32'd0), 1'b0, '0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 38;
    rx_idle_pct = 81;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_write) write_reg(directed_rows[r].reg_idx, directed_rows[r].wval);
      else send_event(directed_rows[r].ev, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int phase = 0; phase < 6; phase++) begin
      tx_idle_pct = (phase < 2) ? 38 : (phase < 4) ? 81 : 0;
      rx_idle_pct = (phase < 2) ? 81 : (phase < 4) ? 38 : 0;
      map = {$urandom(), $urandom()};
      case (phase)
        0: begin
          write_reg(pva_pkg::REG_VOICE_COUNT, 64'd16);
          write_reg(pva_pkg::REG_CHANNEL_MAP, 64'd0);
          write_reg(pva_pkg::REG_MUTE_TICKS, 64'd3);
        end
        1: begin
          for (int i = 0; i < NUM_VOICES; i++) map[4*i +: 4] = 4'($urandom_range(3));
          write_reg(pva_pkg::REG_VOICE_COUNT, 64'd31);
          write_reg(pva_pkg::REG_CHANNEL_MAP, map);
          write_reg(pva_pkg::REG_MUTE_TICKS, 64'd0);
        end
        2: begin
          write_reg(pva_pkg::REG_VOICE_COUNT, 64'd8);
          write_reg(pva_pkg::REG_CHANNEL_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(pva_pkg::REG_MUTE_TICKS, 64'hFFFFF);
        end
        3: begin
          for (int i = 0; i < NUM_VOICES; i++) map[4*i +: 4] = 4'($urandom_range(5));
          write_reg(pva_pkg::REG_VOICE_COUNT, 64'($urandom_range(1, 16)));
          write_reg(pva_pkg::REG_CHANNEL_MAP, map);
          write_reg(pva_pkg::REG_MUTE_TICKS, 64'($urandom_range(1, 6)));
        end
        4: begin
          write_reg(pva_pkg::REG_VOICE_COUNT, 64'd5);
          write_reg(pva_pkg::REG_CHANNEL_MAP, map);
          write_reg(pva_pkg::REG_MUTE_TICKS, 64'd2);
        end
        default: begin
          for (int i = 0; i < NUM_VOICES; i++) map[4*i +: 4] = 4'($urandom_range(2));
          write_reg(pva_pkg::REG_VOICE_COUNT, 64'd16);
          write_reg(pva_pkg::REG_CHANNEL_MAP, map);
          write_reg(pva_pkg::REG_MUTE_TICKS, 64'($urandom_range(4)));
        end
      endcase
      for (int k = 0; k < PHASE_EVENTS; k++) begin
        if (k == PHASE_EVENTS / 2) wait_results_drained();
        if (phase == 5 && k == 10) hold_start = 1'b1;
        send_event(random_event(), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d events over six register settings and three backpressure mixes.",
             events_sent);
    $display("Results: %0d starts, %0d releases, %0d tick reports, %0d with no voice.",
             cmd_seen[pva_pkg::CMD_START], cmd_seen[pva_pkg::CMD_RELEASE],
             cmd_seen[pva_pkg::CMD_TICK], cmd_seen[pva_pkg::CMD_NONE]);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_cmds.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
